/* design/fat_pkg.sv */
// Package for the file allocation table engine: sizes, codes, request and
// response types, sequencer states and the link table reset pattern.
// No dependencies.
`default_nettype none

package fat_pkg;

  localparam int NUM_BLOCKS   = 128;
  localparam int BLK_W        = 7;
  localparam int LINK_W       = 8;
  localparam int ROOT_ENTRIES = 8;
  localparam int SLOT_W       = 3;
  localparam int FAT_BLOCKS   = 7;
  localparam int KEY_BITS     = 64;

  localparam logic [LINK_W-1:0] RESERVED_MARK = 8'hFF;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_REMOVE = 3'd1,
    OP_ADD    = 3'd2,
    OP_DELETE = 3'd3,
    OP_NEXT   = 3'd4,
    OP_FIRST  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EXISTS      = 3'd1,
    ST_ROOT_FULL   = 3'd2,
    ST_NO_FILE     = 3'd3,
    ST_DISK_FULL   = 3'd4,
    ST_NOT_IN_FILE = 3'd5,
    ST_NOT_EMPTY   = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_EXEC,
    S_A_HEAD, S_A_NEXT, S_A_CLR, S_A_TAILRD, S_A_WALK,
    S_W_CHECK, S_W_NEXT, S_F_GOT,
    S_D_GOT0, S_D_WRBLK, S_D_WRHEAD, S_DONE
  } fsm_e;

  typedef struct packed {
    logic [2:0]          operation;
    logic [KEY_BITS-1:0] file_key;
    logic [BLK_W-1:0]    block_number;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [BLK_W-1:0] result_block;
  } rsp_t;

  // link table contents after reset
  function automatic logic [LINK_W-1:0] init_link(input logic [BLK_W-1:0] idx);
    logic [LINK_W-1:0] v;
    v = 8'd0;
    if (idx == 7'd0) begin
      v = LINK_W'(FAT_BLOCKS + 2);
    end else if (idx == 7'd1) begin
      v = 8'd1;
    end else if (idx < BLK_W'(FAT_BLOCKS + 2)) begin
      v = RESERVED_MARK;
    end else if (idx != BLK_W'(NUM_BLOCKS - 1)) begin
      v = {1'b0, idx} + 8'd1;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/fat_block_allocator.sv */
// File allocation table engine: root directory, link table and sequencer.
// Depends on fat_pkg.
//
// Usage: requests enter on in_req_i with in_valid_i/in_stall_o, one result
// per request leaves on out_rsp_o with out_valid_o/out_stall_i.
// After reset the link table is written with its initial pattern, one
// entry a cycle, while in_stall_o stays high.
// A request is handled by one sequencer around a single-port link memory
// with a registered read: a directory scan over the 8 root entries (one
// key compare a cycle), then the tail walk of an add in S_A_WALK or the
// chain search of a delete or next in S_W_CHECK and S_W_NEXT. Create,
// remove and first go from the scan through S_EXEC to S_DONE; the longest
// request is a delete of the last block of a 119-block chain.
// One request is in work at a time; in_stall_o is low only when the
// sequencer is idle.
// The result sits in an output register; the next request is taken while
// it waits. A stalled receiver holds a finished result in the sequencer
// until the output register frees.
`default_nettype none

module fat_block_allocator import fat_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_rsp_o
);

  fsm_e state_q, state_d;

  logic [2:0]          op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [BLK_W-1:0]    blk_q, blk_d;
  logic [BLK_W-1:0]    idx_q, idx_d;
  logic                hit_q, hit_d, free_hit_q, free_hit_d;
  logic [SLOT_W-1:0]   slot_q, slot_d, free_q, free_d;
  logic [LINK_W-1:0]   cur_q, cur_d, tmp_q, tmp_d;
  logic [BLK_W-1:0]    prev_q, prev_d;
  logic [BLK_W:0]      steps_q, steps_d;
  status_e             status_q, status_d;
  logic [BLK_W-1:0]    rblk_q, rblk_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_q, out_d;

  logic [KEY_BITS-1:0] dir_key_q [ROOT_ENTRIES];
  logic                dir_valid_q [ROOT_ENTRIES];
  logic [BLK_W-1:0]    dir_first_q [ROOT_ENTRIES];

  logic              dir_create, dir_clear, dir_first_we;
  logic [BLK_W-1:0]  dir_first_val;

  logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
  logic [LINK_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [BLK_W-1:0]  mem_waddr, mem_raddr;
  logic [LINK_W-1:0] mem_wdata;

  logic [SLOT_W-1:0] scan_idx;
  logic              key_match;
  logic [BLK_W-1:0]  first_blk;
  logic              chain_ok, rd_ok;

  assign scan_idx  = idx_q[SLOT_W-1:0];
  assign key_match = dir_valid_q[scan_idx] && (dir_key_q[scan_idx] == key_q);
  assign first_blk = dir_first_q[slot_q];
  assign chain_ok  = (cur_q != '0) && !cur_q[LINK_W-1] && !steps_q[BLK_W];
  assign rd_ok     = (rdata_q != '0) && !rdata_q[LINK_W-1] && !steps_q[BLK_W];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:    if (idx_q == BLK_W'(NUM_BLOCKS - 1)) state_d = S_IDLE;
      S_IDLE:    if (in_valid_i) state_d = S_SCAN;
      S_SCAN:    if (scan_idx == SLOT_W'(ROOT_ENTRIES - 1)) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        if (hit_q) begin
          if (op_q == OP_ADD) begin
            state_d = S_A_HEAD;
          end else if ((op_q == OP_DELETE || op_q == OP_NEXT) && blk_q != '0) begin
            state_d = S_W_CHECK;
          end
        end
      end
      S_A_HEAD:   state_d = ((rdata_q == '0) || rdata_q[LINK_W-1]) ? S_DONE : S_A_NEXT;
      S_A_NEXT:   state_d = S_A_CLR;
      S_A_CLR:    state_d = (first_blk == '0) ? S_DONE : S_A_TAILRD;
      S_A_TAILRD: state_d = S_A_WALK;
      S_A_WALK:   if (!rd_ok) state_d = S_DONE;
      S_W_CHECK: begin
        if (!chain_ok) state_d = S_DONE;
        else if (cur_q[BLK_W-1:0] == blk_q) state_d = S_F_GOT;
        else state_d = S_W_NEXT;
      end
      S_W_NEXT:   state_d = S_W_CHECK;
      S_F_GOT:    state_d = (op_q == OP_NEXT) ? S_DONE : S_D_GOT0;
      S_D_GOT0:   state_d = S_D_WRBLK;
      S_D_WRBLK:  state_d = S_D_WRHEAD;
      S_D_WRHEAD: state_d = S_DONE;
      S_DONE:     if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:    state_d = S_INIT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d = op_q; key_d = key_q; blk_d = blk_q; idx_d = idx_q;
    hit_d = hit_q; slot_d = slot_q; free_hit_d = free_hit_q; free_d = free_q;
    cur_d = cur_q; tmp_d = tmp_q; prev_d = prev_q; steps_d = steps_q;
    status_d = status_q; rblk_d = rblk_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    dir_create = 1'b0; dir_clear = 1'b0; dir_first_we = 1'b0; dir_first_val = '0;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
    mem_re = 1'b0; mem_raddr = '0;
    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = init_link(idx_q);
        idx_d     = idx_q + 1'b1;
      end
      S_IDLE: begin
        op_d = in_req_i.operation; key_d = in_req_i.file_key;
        blk_d = in_req_i.block_number;
        idx_d = '0; hit_d = 1'b0; free_hit_d = 1'b0;
        slot_d = '0; free_d = '0;
      end
      S_SCAN: begin
        if (key_match && !hit_q) begin
          hit_d = 1'b1; slot_d = scan_idx;
        end
        if (!dir_valid_q[scan_idx] && !free_hit_q) begin
          free_hit_d = 1'b1; free_d = scan_idx;
        end
        idx_d = idx_q + 1'b1;
      end
      S_EXEC: begin
        status_d = ST_OK; rblk_d = '0;
        cur_d = {1'b0, first_blk}; prev_d = '0; steps_d = '0;
        unique case (op_q)
          OP_CREATE: begin
            if (hit_q) status_d = ST_EXISTS;
            else if (free_hit_q) dir_create = 1'b1;
            else status_d = ST_ROOT_FULL;
          end
          OP_REMOVE: begin
            if (!hit_q) status_d = ST_NO_FILE;
            else if (first_blk != '0) status_d = ST_NOT_EMPTY;
            else dir_clear = 1'b1;
          end
          OP_ADD: begin
            if (!hit_q) status_d = ST_NO_FILE;
            else mem_re = 1'b1;
          end
          OP_DELETE, OP_NEXT: begin
            if (!hit_q) status_d = ST_NO_FILE;
            else if (blk_q == '0) status_d = ST_NOT_IN_FILE;
          end
          OP_FIRST: begin
            if (!hit_q) status_d = ST_NO_FILE;
            else rblk_d = first_blk;
          end
          default: ;
        endcase
      end
      S_A_HEAD: begin
        if ((rdata_q == '0) || rdata_q[LINK_W-1]) begin
          status_d = ST_DISK_FULL;
        end else begin
          tmp_d = rdata_q; mem_re = 1'b1; mem_raddr = rdata_q[BLK_W-1:0];
        end
      end
      S_A_NEXT: begin
        mem_we = 1'b1; mem_waddr = '0; mem_wdata = rdata_q;
      end
      S_A_CLR: begin
        mem_we = 1'b1; mem_waddr = tmp_q[BLK_W-1:0]; mem_wdata = '0;
        rblk_d = tmp_q[BLK_W-1:0];
        if (first_blk == '0) begin
          dir_first_we = 1'b1; dir_first_val = tmp_q[BLK_W-1:0];
        end
      end
      S_A_TAILRD: begin
        mem_re = 1'b1; mem_raddr = cur_q[BLK_W-1:0];
      end
      S_A_WALK: begin
        if (rd_ok) begin
          cur_d = rdata_q; steps_d = steps_q + 1'b1;
          mem_re = 1'b1; mem_raddr = rdata_q[BLK_W-1:0];
        end else begin
          mem_we = 1'b1; mem_waddr = cur_q[BLK_W-1:0]; mem_wdata = tmp_q;
        end
      end
      S_W_CHECK: begin
        if (!chain_ok) begin
          status_d = ST_NOT_IN_FILE;
        end else begin
          mem_re = 1'b1; mem_raddr = cur_q[BLK_W-1:0];
          if (cur_q[BLK_W-1:0] != blk_q) prev_d = cur_q[BLK_W-1:0];
        end
      end
      S_W_NEXT: begin
        cur_d = rdata_q; steps_d = steps_q + 1'b1;
      end
      S_F_GOT: begin
        if (op_q == OP_NEXT) begin
          rblk_d = rdata_q[BLK_W-1:0];
        end else begin
          tmp_d = rdata_q; mem_re = 1'b1; mem_raddr = '0;
        end
      end
      S_D_GOT0: begin
        cur_d = rdata_q;
        if (prev_q == '0) begin
          dir_first_we = 1'b1; dir_first_val = tmp_q[BLK_W-1:0];
        end else begin
          mem_we = 1'b1; mem_waddr = prev_q; mem_wdata = tmp_q;
        end
      end
      S_D_WRBLK: begin
        mem_we = 1'b1; mem_waddr = blk_q; mem_wdata = cur_q;
      end
      S_D_WRHEAD: begin
        mem_we = 1'b1; mem_waddr = '0; mem_wdata = {1'b0, blk_q};
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.status = status_q;
          out_d.result_block = rblk_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; blk_q <= blk_d;
    hit_q <= hit_d; slot_q <= slot_d; free_hit_q <= free_hit_d; free_q <= free_d;
    cur_q <= cur_d; tmp_q <= tmp_d; prev_q <= prev_d; steps_q <= steps_d;
    status_q <= status_d; rblk_q <= rblk_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROOT_ENTRIES; i++) begin
        dir_valid_q[i] <= 1'b0;
        dir_first_q[i] <= '0;
      end
    end else begin
      if (dir_create) begin
        dir_valid_q[free_q] <= 1'b1;
        dir_first_q[free_q] <= '0;
      end
      if (dir_clear) dir_valid_q[slot_q] <= 1'b0;
      if (dir_first_we) dir_first_q[slot_q] <= dir_first_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dir_create) dir_key_q[free_q] <= key_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= link_mem[mem_raddr];
  end

endmodule

`default_nettype wire
